// ----- rtl/lwl_pkg.sv -----
// Shared types and constants for the weighted-latency line tour block.
package lwl_pkg;

    // Field and register widths.
    localparam int POS_W      = 16;
    localparam int WGT_W      = 16;
    localparam int TPD_W      = 8;
    localparam int COST_W     = 62;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Default capacity of the customer list.
    localparam int MAX_POINTS_DEF = 256;

    // Saturation value of every cost sum and product.
    localparam logic [COST_W-1:0] COST_CAP = {COST_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_PER_DIST = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_CMP,
        S_PF_INIT,
        S_PF_RD,
        S_PF_WR,
        S_ROW_RD,
        S_ROW_RD2,
        S_ROW_CAP,
        S_J_RD,
        S_J_OUT,
        S_J_MUL,
        S_J_ADD,
        S_FIN
    } t_state;

endpackage

// ----- rtl/line_weighted_latency_interval_dp.sv -----
// Weighted-latency tour on a line. Customers arrive as requests of (position, weight) and are
// kept sorted in a RAM; an insertion shifts stored entries upward one at a time, reading in
// S_SH_RD and comparing and writing in S_SH_CMP, and the sequencer stays busy until the new
// entry is in its slot. A request dropped for lack of room and without last leaves the
// sequencer idle. A request with last set then inserts the start point the same way, builds
// prefix weight sums over the n points including the start, and runs the interval recurrence
// row by row from the start index s down to 0: each row reads point i, point i + 1 and its
// prefix sum, then each column j from s to n - 1 passes read, operand, multiply and add states
// in order, writing its entry back to the row RAM; the column j = i is only set to zero.
// The S_FIN state then scales the minimum by time_per_distance and loads the result register.
// Further requests are taken only while the sequencer is idle; a finished result may wait at
// the output while the next points load.
module line_weighted_latency_interval_dp #(
    parameter int MAX_POINTS = lwl_pkg::MAX_POINTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Customer request channel.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lwl_pkg::POS_W-1:0]       i_position,
    input  logic [lwl_pkg::WGT_W-1:0]       i_weight,
    input  logic                            i_last,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lwl_pkg::COST_W-1:0]      o_total_cost,
    // Configuration write port.
    input  logic                            i_cfg_wr_en,
    input  logic [lwl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lwl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lwl_pkg::*;

    localparam int NPTS = MAX_POINTS + 1;
    localparam int AW   = $clog2(NPTS);
    localparam int NW   = $clog2(NPTS + 1);
    localparam int PSW  = WGT_W + $clog2(NPTS);
    localparam int WW   = PSW + 1;
    localparam int MW   = WW + POS_W;
    localparam int PW_W = POS_W + WGT_W;

    t_state r_state, n_state;

    // Control and datapath registers.
    logic [AW-1:0]     r_cnt;
    logic [AW-1:0]     r_idx;
    logic [POS_W-1:0]  r_p;
    logic [WGT_W-1:0]  r_w;
    logic              r_last;
    logic              r_is_start;
    logic [AW-1:0]     r_s;
    logic [NW-1:0]     r_n;
    logic [PSW-1:0]    r_acc;
    logic [PSW-1:0]    r_ptot;
    logic [AW-1:0]     r_i;
    logic [AW-1:0]     r_j;
    logic [POS_W-1:0]  r_pos_i;
    logic [WGT_W-1:0]  r_w_i;
    logic [PSW-1:0]    r_p_i;
    logic [POS_W-1:0]  r_pos_i1;
    logic [WW-1:0]     r_wi, r_wj;
    logic [POS_W-1:0]  r_d1, r_d2, r_d4;
    logic [POS_W-1:0]  r_pos_j;
    logic [COST_W-1:0] r_old_l, r_old_r;
    logic [MW-1:0]     r_m1, r_m2, r_m3, r_m4;
    logic [COST_W-1:0] r_prev_l, r_prev_r;
    logic [POS_W-1:0]  r_prev_pos;
    logic [POS_W-1:0]  r_start_pos;
    logic [TPD_W-1:0]  r_tpd;
    logic              r_out_valid;
    logic [COST_W-1:0] r_total;

    // Memory ports.
    logic              pw_we;
    logic [AW-1:0]     pw_waddr, pw_raddr;
    logic [PW_W-1:0]   pw_wdata, pw_q;
    logic              ps_we;
    logic [NW-1:0]     ps_waddr, ps_raddr;
    logic [PSW-1:0]    ps_wdata, ps_q;
    logic              lr_we;
    logic [AW-1:0]     lr_waddr, lr_raddr;
    logic [2*COST_W-1:0] lr_wdata, lr_q;

    // Sorted points, prefix weight sums, and one row of the interval table.
    lwl_ram #(.WIDTH(PW_W), .DEPTH(NPTS)) u_pw_ram (
        .i_clk(i_clk), .i_wr_en(pw_we), .i_wr_addr(pw_waddr), .i_wr_data(pw_wdata),
        .i_rd_addr(pw_raddr), .o_rd_data(pw_q)
    );
    lwl_ram #(.WIDTH(PSW), .DEPTH(NPTS + 1)) u_ps_ram (
        .i_clk(i_clk), .i_wr_en(ps_we), .i_wr_addr(ps_waddr), .i_wr_data(ps_wdata),
        .i_rd_addr(ps_raddr), .o_rd_data(ps_q)
    );
    lwl_ram #(.WIDTH(2 * COST_W), .DEPTH(NPTS)) u_lr_ram (
        .i_clk(i_clk), .i_wr_en(lr_we), .i_wr_addr(lr_waddr), .i_wr_data(lr_wdata),
        .i_rd_addr(lr_raddr), .o_rd_data(lr_q)
    );

    logic [POS_W-1:0] q_pos;
    logic [WGT_W-1:0] q_wgt;
    assign q_pos = pw_q[PW_W-1:WGT_W];
    assign q_wgt = pw_q[WGT_W-1:0];

    // Shift test: customers go after equal positions, the start goes ahead of them.
    logic greater;
    assign greater = r_is_start ? (q_pos >= r_p) : (q_pos > r_p);

    logic ins_done;
    assign ins_done = ((r_state == S_SH_RD) && (r_idx == '0)) ||
                      ((r_state == S_SH_CMP) && !greater);

    logic accept;
    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    logic room;
    assign room = (r_cnt < AW'(MAX_POINTS));

    // Prefix sum step and column bookkeeping.
    logic [PSW-1:0] pf_sum;
    assign pf_sum = r_acc + PSW'(q_wgt);

    logic [NW-1:0] j_plus1;
    logic          j_last;
    logic          j_skip;
    assign j_plus1 = NW'(r_j) + NW'(1);
    assign j_last  = (j_plus1 == r_n);
    assign j_skip  = (r_i == r_j);

    logic [NW-1:0] pf_next;
    assign pf_next = NW'(r_j) + NW'(1);

    // Weight of all points outside the interval [i, j].
    logic [WW-1:0] outside;
    assign outside = WW'(r_p_i) + WW'(r_ptot) - WW'(ps_q);

    // Saturating candidate costs and the new table entries.
    logic [COST_W:0]   s1, s2, s3, s4;
    logic [COST_W-1:0] c1, c2, c3, c4, nl, nr;
    assign s1 = {1'b0, r_old_l}  + (COST_W+1)'(r_m1);
    assign s2 = {1'b0, r_old_r}  + (COST_W+1)'(r_m2);
    assign s3 = {1'b0, r_prev_l} + (COST_W+1)'(r_m3);
    assign s4 = {1'b0, r_prev_r} + (COST_W+1)'(r_m4);
    assign c1 = (s1 > {1'b0, COST_CAP}) ? COST_CAP : s1[COST_W-1:0];
    assign c2 = (s2 > {1'b0, COST_CAP}) ? COST_CAP : s2[COST_W-1:0];
    assign c3 = (s3 > {1'b0, COST_CAP}) ? COST_CAP : s3[COST_W-1:0];
    assign c4 = (s4 > {1'b0, COST_CAP}) ? COST_CAP : s4[COST_W-1:0];
    assign nl = (r_i < r_s) ? ((c1 < c2) ? c1 : c2) : COST_CAP;
    assign nr = (r_j > r_s) ? ((c3 < c4) ? c3 : c4) : COST_CAP;

    // Final scaling by the time per unit distance, saturated.
    logic [COST_W-1:0]       best;
    logic [COST_W+TPD_W-1:0] scaled;
    assign best   = (r_prev_l < r_prev_r) ? r_prev_l : r_prev_r;
    assign scaled = best * r_tpd;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (room || i_last) begin
                        n_state = S_SH_RD;
                    end
                end
            end
            S_SH_RD: begin
                if (ins_done) begin
                    n_state = r_is_start ? S_PF_INIT : (r_last ? S_SH_RD : S_IDLE);
                end else begin
                    n_state = S_SH_CMP;
                end
            end
            S_SH_CMP: begin
                if (ins_done) begin
                    n_state = r_is_start ? S_PF_INIT : (r_last ? S_SH_RD : S_IDLE);
                end else begin
                    n_state = S_SH_RD;
                end
            end
            S_PF_INIT: n_state = S_PF_RD;
            S_PF_RD:   n_state = S_PF_WR;
            S_PF_WR:   n_state = (pf_next == r_n) ? S_ROW_RD : S_PF_RD;
            S_ROW_RD:  n_state = S_ROW_RD2;
            S_ROW_RD2: n_state = S_ROW_CAP;
            S_ROW_CAP: n_state = S_J_RD;
            S_J_RD: begin
                if (j_skip) begin
                    n_state = j_last ? ((r_i == '0) ? S_FIN : S_ROW_RD) : S_J_RD;
                end else begin
                    n_state = S_J_OUT;
                end
            end
            S_J_OUT: n_state = S_J_MUL;
            S_J_MUL: n_state = S_J_ADD;
            S_J_ADD: n_state = j_last ? ((r_i == '0) ? S_FIN : S_ROW_RD) : S_J_RD;
            S_FIN:   n_state = r_out_valid ? S_FIN : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        pw_we    = 1'b0;
        pw_waddr = r_idx;
        pw_wdata = {r_p, r_w};
        pw_raddr = r_idx - AW'(1);
        ps_we    = 1'b0;
        ps_waddr = pf_next;
        ps_wdata = pf_sum;
        ps_raddr = j_plus1;
        lr_we    = 1'b0;
        lr_waddr = r_j;
        lr_wdata = {nl, nr};
        lr_raddr = r_j;
        case (r_state)
            S_SH_RD: begin
                pw_we = ins_done;
            end
            S_SH_CMP: begin
                pw_we = 1'b1;
                if (greater) begin
                    pw_wdata = pw_q;
                end
            end
            S_PF_INIT: begin
                ps_we    = 1'b1;
                ps_waddr = '0;
                ps_wdata = '0;
            end
            S_PF_RD: begin
                pw_raddr = r_j;
            end
            S_PF_WR: begin
                ps_we = 1'b1;
            end
            S_ROW_RD: begin
                pw_raddr = r_i;
                ps_raddr = NW'(r_i);
            end
            S_ROW_RD2: begin
                pw_raddr = r_i + AW'(1);
            end
            S_J_RD: begin
                pw_raddr = r_j;
                if (j_skip) begin
                    lr_we    = 1'b1;
                    lr_wdata = '0;
                end
            end
            S_J_ADD: begin
                lr_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer registers and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_start_pos <= '0;
            r_tpd       <= TPD_W'(1);
        end else begin
            r_state <= n_state;

            // Configuration writes.
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_START_POS:     r_start_pos <= i_cfg_data[POS_W-1:0];
                    CFG_TIME_PER_DIST: r_tpd       <= i_cfg_data[TPD_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_last;
                        r_idx  <= r_cnt;
                        if (room) begin
                            r_is_start <= 1'b0;
                            r_p        <= i_position;
                            r_w        <= i_weight;
                        end else begin
                            r_is_start <= 1'b1;
                            r_p        <= r_start_pos;
                            r_w        <= '0;
                        end
                    end
                end
                S_SH_RD, S_SH_CMP: begin
                    if (ins_done) begin
                        if (r_is_start) begin
                            r_s <= r_idx;
                            r_n <= NW'(r_cnt) + NW'(1);
                        end else begin
                            r_cnt      <= r_cnt + AW'(1);
                            r_idx      <= r_cnt + AW'(1);
                            r_is_start <= 1'b1;
                            r_p        <= r_start_pos;
                            r_w        <= '0;
                        end
                    end else if (r_state == S_SH_CMP) begin
                        r_idx <= r_idx - AW'(1);
                    end
                end
                S_PF_INIT: begin
                    r_acc <= '0;
                    r_j   <= '0;
                end
                S_PF_WR: begin
                    r_acc <= pf_sum;
                    r_j   <= r_j + AW'(1);
                    if (pf_next == r_n) begin
                        r_ptot <= pf_sum;
                        r_i    <= r_s;
                    end
                end
                S_ROW_RD2: begin
                    r_pos_i <= q_pos;
                    r_w_i   <= q_wgt;
                    r_p_i   <= ps_q;
                end
                S_ROW_CAP: begin
                    r_pos_i1 <= q_pos;
                    r_j      <= r_s;
                end
                S_J_RD: begin
                    if (j_skip) begin
                        r_prev_l   <= '0;
                        r_prev_r   <= '0;
                        r_prev_pos <= r_pos_i;
                        if (j_last) begin
                            r_i <= r_i - AW'(1);
                        end else begin
                            r_j <= r_j + AW'(1);
                        end
                    end
                end
                S_J_OUT: begin
                    r_wi    <= outside + WW'(r_w_i);
                    r_wj    <= outside + WW'(q_wgt);
                    r_d1    <= r_pos_i1 - r_pos_i;
                    r_d2    <= q_pos - r_pos_i;
                    r_d4    <= q_pos - r_prev_pos;
                    r_pos_j <= q_pos;
                    r_old_l <= lr_q[2*COST_W-1:COST_W];
                    r_old_r <= lr_q[COST_W-1:0];
                end
                S_J_MUL: begin
                    r_m1 <= r_wi * r_d1;
                    r_m2 <= r_wi * r_d2;
                    r_m3 <= r_wj * r_d2;
                    r_m4 <= r_wj * r_d4;
                end
                S_J_ADD: begin
                    r_prev_l   <= nl;
                    r_prev_r   <= nr;
                    r_prev_pos <= r_pos_j;
                    if (j_last) begin
                        r_i <= r_i - AW'(1);
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                S_FIN: begin
                    if (!r_out_valid) begin
                        r_total     <= (scaled > (COST_W+TPD_W)'(COST_CAP)) ?
                                       COST_CAP : scaled[COST_W-1:0];
                        r_out_valid <= 1'b1;
                        r_cnt       <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_total_cost = r_total;

endmodule

// ----- rtl/lwl_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module lwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
